// ----- sv/etrt_pkg.sv -----
// Package for the energy total / report throttle block.
// Shared types, codes and constants; no dependencies.
package etrt_pkg;

    localparam int TOTAL_BITS = 48;   // width of the running total, 32..64
    localparam int OUT_BITS   = 48;   // energy_total field width
    localparam int TIME_BITS  = 32;
    localparam int READ_BITS  = 32;
    localparam int STEP_BITS  = 16;
    localparam int CFG_BITS   = 32;

    localparam int S_TDATA_BITS = 120;  // 114 payload bits, zero padded
    localparam int S_TUSER_BITS = 2;
    localparam int M_TDATA_BITS = 56;   // 51 payload bits, zero padded

    localparam logic [TIME_BITS-1:0] SAVE_INTERVAL_RST = 32'd300000;
    localparam logic [TIME_BITS-1:0] MIN_GAP_RST       = 32'd10000;
    localparam logic [TIME_BITS-1:0] MAX_GAP_RST       = 32'd300000;
    localparam logic [STEP_BITS-1:0] REPORT_STEP_RST   = 16'd10;

    typedef enum logic [1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_CHECK  = 2'd1,
        ACT_RESET  = 2'd2,
        ACT_LOAD   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        CFG_SAVE_INTERVAL = 2'd0,
        CFG_MIN_GAP       = 2'd1,
        CFG_MAX_GAP       = 2'd2,
        CFG_REPORT_STEP   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] save_interval_ms;
        logic [TIME_BITS-1:0] min_report_gap_ms;
        logic [TIME_BITS-1:0] max_report_gap_ms;
        logic [STEP_BITS-1:0] report_step_wh;
    } cfg_t;

    typedef struct packed {
        action_t              action;
        logic [TIME_BITS-1:0] now_ms;
        logic                 reading_valid;
        logic [READ_BITS-1:0] meter_reading;
        logic [OUT_BITS-1:0]  stored_total;
        logic                 stored_ok;
    } item_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] energy_total;
        logic                report_now;
        logic                save_now;
        logic                meter_clear;
    } result_t;

endpackage

// ----- sv/etrt_cfg.sv -----
// Configuration register file for the energy total block.
// Depends on etrt_pkg.
module etrt_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [etrt_pkg::CFG_BITS-1:0]  cfg_wdata,
    output etrt_pkg::cfg_t                 cfg
);
    import etrt_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SAVE_INTERVAL: cfg_next.save_interval_ms  = cfg_wdata[TIME_BITS-1:0];
                CFG_MIN_GAP:       cfg_next.min_report_gap_ms = cfg_wdata[TIME_BITS-1:0];
                CFG_MAX_GAP:       cfg_next.max_report_gap_ms = cfg_wdata[TIME_BITS-1:0];
                CFG_REPORT_STEP:   cfg_next.report_step_wh    = cfg_wdata[STEP_BITS-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.save_interval_ms  <= SAVE_INTERVAL_RST;
            cfg_reg.min_report_gap_ms <= MIN_GAP_RST;
            cfg_reg.max_report_gap_ms <= MAX_GAP_RST;
            cfg_reg.report_step_wh    <= REPORT_STEP_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/etrt_in_stage.sv -----
// Input register stage: unpacks the slave stream word and holds one item.
// Depends on etrt_pkg.
module etrt_in_stage (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [etrt_pkg::S_TDATA_BITS-1:0] s_tdata,
    input  logic [etrt_pkg::S_TUSER_BITS-1:0] s_tuser,
    input  logic                              take,     // core consumes the held item
    output logic                              item_valid,
    output etrt_pkg::item_t                   item
);
    import etrt_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;
    logic  load;

    assign s_tready = !valid_reg || take;
    assign load     = s_tvalid && s_tready;

    always_comb begin
        item_next.action        = action_t'(s_tuser);
        item_next.now_ms        = s_tdata[31:0];
        item_next.reading_valid = s_tdata[32];
        item_next.meter_reading = s_tdata[64:33];
        item_next.stored_total  = s_tdata[112:65];
        item_next.stored_ok     = s_tdata[113];
        valid_next              = load || (valid_reg && !take);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- sv/etrt_core.sv -----
// Energy accumulator state and per-word decision logic.
// Depends on etrt_pkg.
module etrt_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  etrt_pkg::item_t   item,
    input  etrt_pkg::cfg_t    cfg,
    output etrt_pkg::result_t result
);
    import etrt_pkg::*;

    logic [TOTAL_BITS-1:0] total_reg,       total_next;
    logic [READ_BITS-1:0]  prev_reading_reg, prev_reading_next;
    logic [TOTAL_BITS-1:0] reported_reg,    reported_next;
    logic [TIME_BITS-1:0]  last_save_reg,   last_save_next;
    logic [TIME_BITS-1:0]  last_report_reg, last_report_next;

    logic [READ_BITS-1:0]  delta;
    logic [TIME_BITS-1:0]  save_age;
    logic [TIME_BITS-1:0]  report_age;
    logic [TOTAL_BITS-1:0] rise;
    logic                  rise_hit;
    logic [63:0]           stored_wide;
    logic [63:0]           total_wide;
    logic                  report, save, clear;

    assign delta       = item.meter_reading - prev_reading_reg;
    assign save_age    = item.now_ms - last_save_reg;
    assign report_age  = item.now_ms - last_report_reg;
    // total behind reported counts as no rise
    assign rise        = (total_reg >= reported_reg) ? (total_reg - reported_reg)
                                                     : '0;
    assign rise_hit    = rise >= TOTAL_BITS'(cfg.report_step_wh);
    assign stored_wide = 64'(item.stored_total);

    always_comb begin
        total_next        = total_reg;
        prev_reading_next = prev_reading_reg;
        reported_next     = reported_reg;
        last_save_next    = last_save_reg;
        last_report_next  = last_report_reg;
        report            = 1'b0;
        save              = 1'b0;
        clear             = 1'b0;
        unique case (item.action)
            ACT_SAMPLE: begin
                if (item.reading_valid) begin
                    if (item.meter_reading >= prev_reading_reg) begin
                        total_next = total_reg + TOTAL_BITS'(delta);
                    end
                    prev_reading_next = item.meter_reading;
                    if (save_age >= cfg.save_interval_ms) begin
                        save           = 1'b1;
                        last_save_next = item.now_ms;
                    end
                end
            end
            ACT_CHECK: begin
                if (report_age >= cfg.min_report_gap_ms &&
                    (report_age >= cfg.max_report_gap_ms || rise_hit)) begin
                    report           = 1'b1;
                    reported_next    = total_reg;
                    last_report_next = item.now_ms;
                end
            end
            ACT_RESET: begin
                total_next        = '0;
                prev_reading_next = '0;
                reported_next     = '0;
                save              = 1'b1;
                clear             = 1'b1;
            end
            ACT_LOAD: begin
                total_next    = item.stored_ok ? stored_wide[TOTAL_BITS-1:0] : '0;
                reported_next = total_next;
            end
            default: ;
        endcase
    end

    assign total_wide          = 64'(total_next);
    assign result.energy_total = total_wide[OUT_BITS-1:0];
    assign result.report_now   = report;
    assign result.save_now     = save;
    assign result.meter_clear  = clear;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg        <= '0;
            prev_reading_reg <= '0;
            reported_reg     <= '0;
            last_save_reg    <= '0;
            last_report_reg  <= '0;
        end else if (fire) begin
            total_reg        <= total_next;
            prev_reading_reg <= prev_reading_next;
            reported_reg     <= reported_next;
            last_save_reg    <= last_save_next;
            last_report_reg  <= last_report_next;
        end
    end

endmodule

// ----- sv/etrt_out_stage.sv -----
// Result register: holds one result word for the master stream.
// Depends on etrt_pkg.
module etrt_out_stage (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              load,
    input  etrt_pkg::result_t                 result,
    output logic                              free,     // can take a word this cycle
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [etrt_pkg::M_TDATA_BITS-1:0] m_tdata
);
    import etrt_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign free       = !valid_reg || m_tready;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'b0, data_reg.meter_clear, data_reg.save_now,
                       data_reg.report_now, data_reg.energy_total};

endmodule

// ----- sv/energy_total_with_report_throttle_unit.sv -----
// Top level of the energy total accumulator with save/report throttling.
// Depends on etrt_pkg, etrt_cfg, etrt_in_stage, etrt_core, etrt_out_stage.
//
//  channel  | dir | handshake          | contents
//  ---------+-----+--------------------+---------------------------------------
//  s_       | in  | s_tvalid/s_tready  | tuser action, tdata sample/load word
//  m_       | out | m_tvalid/m_tready  | tdata total and report/save/clear
//  cfg_     | in  | cfg_we             | cfg_index, cfg_wdata, no read-back
//
// One word per cycle sustained while m_tready stays high; a word taken goes
// through the input register, then the result register that the state update
// shares, onto m_tdata. All state is updated in the single cycle the word moves
// to the result register. Reset is synchronous; nothing needs clearing after it.
// A stall on m_tready holds the result; one more word can wait at the input.
module energy_total_with_report_throttle_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [31:0] now_ms, [32] reading_valid, [64:33] meter_reading,
    // [112:65] stored_total, [113] stored_ok
    input  logic [etrt_pkg::S_TDATA_BITS-1:0] s_tdata,
    // [1:0] action
    input  logic [etrt_pkg::S_TUSER_BITS-1:0] s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [47:0] energy_total, [48] report_now, [49] save_now, [50] meter_clear
    output logic [etrt_pkg::M_TDATA_BITS-1:0] m_tdata,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [etrt_pkg::CFG_BITS-1:0]     cfg_wdata
);
    import etrt_pkg::*;

    cfg_t    cfg;
    item_t   item;
    result_t result;
    logic    item_valid;
    logic    out_free;
    logic    fire;

    assign fire = item_valid && out_free;

    etrt_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    etrt_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    etrt_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item),
        .cfg     (cfg),
        .result  (result)
    );

    etrt_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- sv/etrt_checker.sv -----
// Port-level checks for the energy total block, bound to the top level.
// Depends on etrt_pkg and energy_total_with_report_throttle_unit.
module etrt_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [etrt_pkg::M_TDATA_BITS-1:0] m_tdata
);
    import etrt_pkg::*;

    // nothing to deliver right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result word changed while stalled");

    // a meter clear only comes from the reset action: save, zero total, no report
    a_clear_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[50] |->
            m_tdata[49] && !m_tdata[48] && (m_tdata[47:0] == 48'd0))
        else $error("meter clear word malformed");

    // a word accepted while no result word is waiting must show up as a result
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && s_tvalid && s_tready |=> ##1 m_tvalid)
        else $error("result word missing two cycles after accept");

endmodule

bind energy_total_with_report_throttle_unit etrt_checker u_etrt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- sim/tb_energy_total_with_report_throttle_unit.sv -----
`timescale 1ns / 100ps
// Self-checking bench for energy_total_with_report_throttle_unit.
// Needs etrt_pkg and the block's RTL; a small class predicts every output word.
module tb_energy_total_with_report_throttle_unit;
    import etrt_pkg::*;

    localparam int LONG_HOLD = 80;

    class energy_tracker;
        cfg_t                  regs;
        logic [TOTAL_BITS-1:0] total_wh;
        logic [TOTAL_BITS-1:0] reported_wh;
        logic [READ_BITS-1:0]  prev_reading;
        logic [TIME_BITS-1:0]  last_save_ms;
        logic [TIME_BITS-1:0]  last_report_ms;
        result_t               due_results[$];
        int                    errors;
        int                    matched;
        int                    report_cnt;
        int                    save_cnt;
        int                    clear_cnt;

        function new();
            regs.save_interval_ms  = SAVE_INTERVAL_RST;
            regs.min_report_gap_ms = MIN_GAP_RST;
            regs.max_report_gap_ms = MAX_GAP_RST;
            regs.report_step_wh    = REPORT_STEP_RST;
            total_wh       = '0;
            reported_wh    = '0;
            prev_reading   = '0;
            last_save_ms   = '0;
            last_report_ms = '0;
            errors         = 0;
            matched        = 0;
            report_cnt     = 0;
            save_cnt       = 0;
            clear_cnt      = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CFG_BITS-1:0] value);
            case (idx)
                CFG_SAVE_INTERVAL: regs.save_interval_ms  = value;
                CFG_MIN_GAP:       regs.min_report_gap_ms = value;
                CFG_MAX_GAP:       regs.max_report_gap_ms = value;
                CFG_REPORT_STEP:   regs.report_step_wh    = value[STEP_BITS-1:0];
            endcase
        endfunction

        // Advance the predicted state by one accepted input word.
        function void step_on_input(item_t w);
            result_t               r;
            logic [TIME_BITS-1:0]  gap;
            logic [READ_BITS-1:0]  delta;
            logic [TOTAL_BITS-1:0] rise;
            r = '0;
            case (w.action)
                ACT_SAMPLE: begin
                    if (w.reading_valid) begin
                        if (w.meter_reading >= prev_reading) begin
                            delta    = w.meter_reading - prev_reading;
                            total_wh = total_wh + TOTAL_BITS'(delta);
                        end
                        prev_reading = w.meter_reading;
                        gap = w.now_ms - last_save_ms;
                        if (gap >= regs.save_interval_ms) begin
                            r.save_now   = 1'b1;
                            last_save_ms = w.now_ms;
                        end
                    end
                end
                ACT_CHECK: begin
                    gap = w.now_ms - last_report_ms;
                    if (gap >= regs.min_report_gap_ms) begin
                        // a total that wrapped below the reported one counts as no rise
                        rise = (total_wh >= reported_wh) ? total_wh - reported_wh : '0;
                        if (gap >= regs.max_report_gap_ms ||
                            rise >= TOTAL_BITS'(regs.report_step_wh)) begin
                            r.report_now   = 1'b1;
                            reported_wh    = total_wh;
                            last_report_ms = w.now_ms;
                        end
                    end
                end
                ACT_RESET: begin
                    total_wh      = '0;
                    prev_reading  = '0;
                    reported_wh   = '0;
                    r.save_now    = 1'b1;
                    r.meter_clear = 1'b1;
                end
                ACT_LOAD: begin
                    total_wh    = w.stored_ok ? TOTAL_BITS'(w.stored_total) : '0;
                    reported_wh = total_wh;
                end
            endcase
            r.energy_total = total_wh[OUT_BITS-1:0];
            due_results.push_back(r);
        endfunction

        function void match_output(logic [M_TDATA_BITS-1:0] data);
            result_t want;
            result_t got;
            if (due_results.size() == 0) begin
                $error("output word 0x%0h with nothing expected", data);
                errors++;
                return;
            end
            want = due_results.pop_front();
            got.energy_total = data[OUT_BITS-1:0];
            got.report_now   = data[OUT_BITS];
            got.save_now     = data[OUT_BITS+1];
            got.meter_clear  = data[OUT_BITS+2];
            if (got.energy_total !== want.energy_total) begin
                $error("energy_total: expected 0x%0h, got 0x%0h",
                       want.energy_total, got.energy_total);
                errors++;
            end
            if (got.report_now !== want.report_now) begin
                $error("report_now: expected %0b, got %0b", want.report_now, got.report_now);
                errors++;
            end
            if (got.save_now !== want.save_now) begin
                $error("save_now: expected %0b, got %0b", want.save_now, got.save_now);
                errors++;
            end
            if (got.meter_clear !== want.meter_clear) begin
                $error("meter_clear: expected %0b, got %0b", want.meter_clear, got.meter_clear);
                errors++;
            end
            matched++;
            report_cnt += want.report_now;
            save_cnt   += want.save_now;
            clear_cnt  += want.meter_clear;
        endfunction
    endclass

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata   = '0;
    logic [S_TUSER_BITS-1:0] s_tuser   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;
    logic                    cfg_we    = 1'b0;
    logic [1:0]              cfg_index = '0;
    logic [CFG_BITS-1:0]     cfg_wdata = '0;

    energy_tracker tracker;

    bit          rx_stalls   = 1'b1;
    bit          tx_gaps     = 1'b1;
    bit          hold_long   = 1'b0;
    int          quiet_words = 0;
    int          hold_item   = -1;
    logic [31:0] clock_ms    = '0;
    logic [31:0] meter_wh    = '0;
    int          time_step_max;
    int          rise_max;

    energy_total_with_report_throttle_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.match_output(m_tdata);
    end

    // Output side: random stall bursts, plus one long hold on request.
    initial begin
        forever begin
            if (hold_long) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_long = 1'b0;
            end else if (rx_stalls && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    task automatic send_word(action_t act, logic [31:0] now, logic valid,
                             logic [31:0] reading, logic [47:0] stored, logic ok);
        item_t w;
        int    gap;
        w.action        = act;
        w.now_ms        = now;
        w.reading_valid = valid;
        w.meter_reading = reading;
        w.stored_total  = stored;
        w.stored_ok     = ok;
        s_tuser  <= act;
        s_tdata  <= {6'b0, ok, stored, reading, valid, now};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        tracker.step_on_input(w);
        if (quiet_words > 0) begin
            quiet_words--;
        end else if (tx_gaps && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 11);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_pipe();
        s_tvalid <= 1'b0;
        while (tracker.due_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Leaves cfg_we high; the caller lowers it after the last write.
    task automatic put_reg(cfg_idx_t idx, logic [CFG_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        tracker.set_reg(idx, value);
    endtask

    task automatic send_random();
        int          pick;
        logic [47:0] stored;
        pick = $urandom_range(0, 99);
        clock_ms = clock_ms + $urandom_range(0, time_step_max);
        if ($urandom_range(0, 39) == 0)
            clock_ms = $urandom;
        if (pick < 45) begin
            if ($urandom_range(0, 14) == 0)
                meter_wh = meter_wh - $urandom_range(1, 1000);
            else if ($urandom_range(0, 49) == 0)
                meter_wh = $urandom;
            else
                meter_wh = meter_wh + $urandom_range(0, rise_max);
            send_word(ACT_SAMPLE, clock_ms, 1'b1, meter_wh, rand48(),
                      1'($urandom_range(0, 1)));
        end else if (pick < 52) begin
            send_word(ACT_SAMPLE, clock_ms, 1'b0, $urandom, rand48(),
                      1'($urandom_range(0, 1)));
        end else if (pick < 88) begin
            send_word(ACT_CHECK, clock_ms, 1'($urandom_range(0, 1)), $urandom, rand48(),
                      1'($urandom_range(0, 1)));
        end else if (pick < 94) begin
            send_word(ACT_RESET, clock_ms, 1'($urandom_range(0, 1)), $urandom, rand48(),
                      1'($urandom_range(0, 1)));
            meter_wh = '0;   // the meter clears its own count as asked
        end else begin
            stored = $urandom_range(0, 1) ? rand48() : 48'($urandom_range(0, 100000));
            send_word(ACT_LOAD, clock_ms, 1'($urandom_range(0, 1)), $urandom, stored,
                      1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_phase(logic [31:0] save_iv, logic [31:0] min_gap,
                             logic [31:0] max_gap, logic [15:0] step,
                             int tstep, int rise, int count);
        drain_pipe();
        put_reg(CFG_SAVE_INTERVAL, save_iv);
        put_reg(CFG_MIN_GAP, min_gap);
        put_reg(CFG_MAX_GAP, max_gap);
        put_reg(CFG_REPORT_STEP, {16'($urandom), step});  // upper bits are don't-care
        cfg_we <= 1'b0;
        time_step_max = tstep;
        rise_max      = rise;
        for (int i = 0; i < count; i++) begin
            if (i == hold_item) begin
                // back-to-back words against a stalled output fill the pipe
                hold_long   = 1'b1;
                quiet_words = 40;
            end
            send_random();
        end
    endtask

    initial begin
        tracker = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, reset values of the limits
        send_word(ACT_CHECK,  32'd0,          1'b0, 32'd0,          48'd0, 1'b0);
        send_word(ACT_SAMPLE, 32'd1000,       1'b1, 32'd100,        48'd0, 1'b0);
        send_word(ACT_SAMPLE, 32'hFFFF_FFFF,  1'b0, 32'hFFFF_FFFF,  48'd0, 1'b0);
        send_word(ACT_SAMPLE, 32'd2000,       1'b1, 32'd50,         48'd0, 1'b0);
        send_word(ACT_SAMPLE, 32'd300000,     1'b1, 32'd60,         48'd0, 1'b0);
        send_word(ACT_CHECK,  32'd5000,       1'b0, 32'd0,          48'd0, 1'b0);
        send_word(ACT_CHECK,  32'd10000,      1'b0, 32'd0,          48'd0, 1'b0);
        send_word(ACT_CHECK,  32'd20000,      1'b0, 32'd0,          48'd0, 1'b0);
        send_word(ACT_CHECK,  32'd310000,     1'b0, 32'd0,          48'd0, 1'b0);
        send_word(ACT_LOAD,   32'd0,          1'b0, 32'd0,   48'hFFFF_FFFF_FFF8, 1'b1);
        // total wraps past 2^48 and falls behind the reported value
        send_word(ACT_SAMPLE, 32'd310500,     1'b1, 32'd80,         48'd0, 1'b0);
        send_word(ACT_CHECK,  32'd320000,     1'b0, 32'd0,          48'd0, 1'b0);
        send_word(ACT_CHECK,  32'd610000,     1'b0, 32'd0,          48'd0, 1'b0);
        send_word(ACT_LOAD,   32'd0,          1'b0, 32'd0,   48'hFFFF_FFFF_FFFF, 1'b0);
        send_word(ACT_RESET,  32'd0,          1'b0, 32'd0,          48'd0, 1'b0);
        send_word(ACT_SAMPLE, 32'hFFFF_FFFF,  1'b1, 32'hFFFF_FFFF,  48'd0, 1'b0);
        send_word(ACT_SAMPLE, 32'd0,          1'b1, 32'd0,          48'd0, 1'b0);
        send_word(ACT_LOAD,   32'd0,          1'b0, 32'd0,   48'hFFFF_FFFF_FFFF, 1'b1);
        send_word(ACT_SAMPLE, 32'd400000,     1'b1, 32'd5,          48'd0, 1'b0);
        send_word(ACT_CHECK,  32'hFFFF_FFFF,  1'b0, 32'd0,          48'd0, 1'b0);
        send_word(ACT_LOAD,   32'd0,          1'b0, 32'd0,          48'd0, 1'b1);
        send_word(ACT_CHECK,  32'd0,          1'b0, 32'd0,          48'd0, 1'b0);

        // random part, one limit setting per phase
        hold_item = 30;
        run_phase(32'd0, 32'd0, 32'd0, 16'd0, 1000, 5, 110);
        hold_item = -1;
        run_phase(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 16'hFFFF, 100000, 5000, 110);
        run_phase(32'd300, 32'hFFFF_FFFF, 32'd0, 16'd0, 1000, 10, 80);
        run_phase(32'd2000, 32'd300, 32'd4000, 16'd50, 700, 20, 160);
        rx_stalls = 1'b0;
        tx_gaps   = 1'b0;
        run_phase(32'd5000, 32'd1000, 32'd20000, 16'd30, 2000, 15, 90);

        drain_pipe();
        repeat (6) @(posedge aclk);
        $display("Checked %0d output words: %0d reports, %0d saves, %0d meter clears.",
                 tracker.matched, tracker.report_cnt, tracker.save_cnt, tracker.clear_cnt);
        $display("Limits covered: reset values, all zero, all ones, mid range; one long stall.");
        if (tracker.errors == 0 && tracker.due_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
